FILE: sv/ettc_pkg.sv
`timescale 1ns / 1ps

package ettc_pkg;

  localparam int CntW = 20;
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  localparam logic [7:0] CH_M  = 8'h4D;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_X  = 8'h58;
  localparam logic [7:0] CH_I  = 8'h49;
  localparam logic [7:0] CH_D  = 8'h44;

  localparam int OpqDepth = 4;
  localparam int OpqAw    = 2;
  localparam int OutDepth = 4;
  localparam int OutAw    = 2;

  localparam logic REG_SKIP = 1'b0;
  localparam logic REG_KEEP = 1'b1;

  typedef struct packed {
    logic [7:0] op_char;
    logic       last_op;
  } in_item_t;

  typedef struct packed {
    logic            is_final;
    logic [7:0]      run_op;
    logic [CntW-1:0] run_length;
    logic [CntW-1:0] match_count;
    logic [CntW-1:0] mismatch_count;
    logic [CntW-1:0] insertion_count;
    logic [CntW-1:0] deletion_count;
    logic [CntW-1:0] softclip_count;
    logic [CntW-1:0] ref_aligned_length;
    logic [CntW-1:0] query_aligned_length;
    logic [CntW-1:0] target_skipped;
    logic [CntW-1:0] target_kept;
  } out_rec_t;

  // One classified operation on its way from the front end to the encoder.
  typedef struct packed {
    logic [7:0]      op;
    logic            take;
    logic            last;
    logic [CntW-1:0] tskip;
    logic [CntW-1:0] tkeep;
  } opq_entry_t;

  typedef struct packed {
    logic [CntW-1:0] match;
    logic [CntW-1:0] mism;
    logic [CntW-1:0] ins;
    logic [CntW-1:0] del;
    logic [CntW-1:0] sclip;
    logic [CntW-1:0] refl;
    logic [CntW-1:0] qry;
  } tally_t;

  function automatic logic [CntW-1:0] sat_add(input logic [CntW-1:0] a,
                                              input logic [CntW-1:0] b);
    logic [CntW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CntW] ? {CntW{1'b1}} : s[CntW-1:0];
  endfunction

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] a);
    return (a == {CntW{1'b1}}) ? a : a + CntOne;
  endfunction

  // Adds a closed run to the tallies. An insertion run that opens the
  // alignment or closes it is counted as soft clip.
  function automatic tally_t flush_tally(input tally_t t, input logic [7:0] op,
                                         input logic [CntW-1:0] n,
                                         input logic soft_ins);
    tally_t r;
    r = t;
    case (op)
      CH_I: begin
        if (soft_ins) r.sclip = sat_add(t.sclip, n);
        else r.ins = sat_add(t.ins, n);
        r.qry = sat_add(t.qry, n);
      end
      CH_M, CH_EQ: begin
        r.match = sat_add(t.match, n);
        r.qry   = sat_add(t.qry, n);
        r.refl  = sat_add(t.refl, n);
      end
      CH_X: begin
        r.mism = sat_add(t.mism, n);
        r.qry  = sat_add(t.qry, n);
        r.refl = sat_add(t.refl, n);
      end
      CH_D: begin
        r.del  = sat_add(t.del, n);
        r.refl = sat_add(t.refl, n);
      end
      default: r = t;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/ettc_front.sv
`timescale 1ns / 1ps

module ettc_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    acc,
  input  ettc_pkg::in_item_t      item,
  input  logic [ettc_pkg::CntW-1:0] skip,
  input  logic [ettc_pkg::CntW-1:0] keep,
  output logic                    enq,
  output ettc_pkg::opq_entry_t    entry
);

  typedef enum logic [1:0] {PH_SKIP, PH_KEEP, PH_ALL, PH_DONE} phase_t;

  phase_t                    phase_r, phase_nxt, ph;
  logic [ettc_pkg::CntW-1:0] qseen_r, qseen_nxt, qs;
  logic [ettc_pkg::CntW-1:0] tskip_r, tskip_nxt, tsk;
  logic [ettc_pkg::CntW-1:0] tkeep_r, tkeep_nxt, tkp;
  logic                      take, uses_q, uses_t;

  always_comb begin
    uses_q = (item.op_char == ettc_pkg::CH_M) || (item.op_char == ettc_pkg::CH_EQ) ||
             (item.op_char == ettc_pkg::CH_X) || (item.op_char == ettc_pkg::CH_I);
    uses_t = (item.op_char == ettc_pkg::CH_M) || (item.op_char == ettc_pkg::CH_EQ) ||
             (item.op_char == ettc_pkg::CH_X) || (item.op_char == ettc_pkg::CH_D);
    ph   = phase_r;
    qs   = qseen_r;
    tsk  = tskip_r;
    tkp  = tkeep_r;
    take = 1'b0;
    // The item that ends the skip phase is judged again by the keep bound.
    if (ph == PH_SKIP) begin
      if (qs < skip) begin
        if (uses_t) tsk = ettc_pkg::sat_inc(tsk);
        if (uses_q) qs = ettc_pkg::sat_inc(qs);
      end else begin
        qs = '0;
        ph = (keep == '0) ? PH_ALL : PH_KEEP;
      end
    end
    if (ph == PH_KEEP) begin
      if (qs < keep) begin
        if (uses_t) tkp = ettc_pkg::sat_inc(tkp);
        if (uses_q) qs = ettc_pkg::sat_inc(qs);
        take = 1'b1;
      end else begin
        ph = PH_DONE;
      end
    end else if (ph == PH_ALL) begin
      take = 1'b1;
    end

    entry.op    = item.op_char;
    entry.take  = take;
    entry.last  = item.last_op;
    entry.tskip = tsk;
    entry.tkeep = tkp;
    enq         = acc && (take || item.last_op);

    phase_nxt = phase_r;
    qseen_nxt = qseen_r;
    tskip_nxt = tskip_r;
    tkeep_nxt = tkeep_r;
    if (acc) begin
      if (item.last_op) begin
        phase_nxt = PH_SKIP;
        qseen_nxt = '0;
        tskip_nxt = '0;
        tkeep_nxt = '0;
      end else begin
        phase_nxt = ph;
        qseen_nxt = qs;
        tskip_nxt = tsk;
        tkeep_nxt = tkp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      qseen_r <= '0;
      tskip_r <= '0;
      tkeep_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      qseen_r <= qseen_nxt;
      tskip_r <= tskip_nxt;
      tkeep_r <= tkeep_nxt;
    end
  end

  a_all_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ALL) |-> (qseen_r == '0))
    else $error("query count moved in keep-all phase");

  a_tkeep_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (tkeep_r != '0) |-> (phase_r == PH_KEEP || phase_r == PH_DONE))
    else $error("target kept count outside keep phase");

endmodule

FILE: sv/ettc_opq.sv
`timescale 1ns / 1ps

module ettc_opq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  ettc_pkg::opq_entry_t wr_data,
  input  logic                 rd_en,
  output ettc_pkg::opq_entry_t rd_data,
  output logic                 valid,
  output logic                 full
);

  ettc_pkg::opq_entry_t mem_r [ettc_pkg::OpqDepth];
  logic [ettc_pkg::OpqAw-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [ettc_pkg::OpqAw:0]   cnt_r, cnt_nxt;
  logic                       do_wr, do_rd;

  always_comb begin
    valid   = (cnt_r != '0);
    full    = (cnt_r == (ettc_pkg::OpqAw + 1)'(ettc_pkg::OpqDepth));
    do_wr   = wr_en && !full;
    do_rd   = rd_en && valid;
    rd_data = mem_r[rp_r];
    wp_nxt  = do_wr ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 1'b1;
    else if (do_rd && !do_wr) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_opq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && full))
    else $error("operation queue written while full");

endmodule

FILE: sv/ettc_back.sv
`timescale 1ns / 1ps

module ettc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 hd_valid,
  input  ettc_pkg::opq_entry_t hd,
  output logic                 hd_pop,
  output logic                 empty,
  input  logic                 pop,
  output ettc_pkg::out_rec_t   out_rec
);

  logic [7:0]                cop_r, cop_nxt, op2;
  logic [ettc_pkg::CntW-1:0] clen_r, clen_nxt, len2;
  logic                      any_r, any_nxt, took_r, took_nxt;
  ettc_pkg::tally_t          tal_r, tal_nxt, fin_tal;
  ettc_pkg::out_rec_t        rec;
  logic                      go, apply, chg, emit, do_pop;

  ettc_pkg::out_rec_t        mem_r [ettc_pkg::OutDepth];
  logic [ettc_pkg::OutAw-1:0] wp_r, rp_r;
  logic [ettc_pkg::OutAw:0]   oc_r, oc_nxt;

  always_comb begin
    go    = hd_valid && (oc_r != (ettc_pkg::OutAw + 1)'(ettc_pkg::OutDepth));
    apply = hd.take && !took_r;
    chg   = apply && (clen_r != '0) && (cop_r != hd.op);

    hd_pop   = 1'b0;
    emit     = 1'b0;
    cop_nxt  = cop_r;
    clen_nxt = clen_r;
    any_nxt  = any_r;
    tal_nxt  = tal_r;
    took_nxt = took_r;
    op2      = cop_r;
    len2     = clen_r;
    fin_tal  = tal_r;

    rec.is_final   = 1'b0;
    rec.run_op     = cop_r;
    rec.run_length = clen_r;

    if (go) begin
      if (chg) begin
        // Operation changes: the open run leaves as an ordinary record.
        // On a last item took_r holds the item at the head for the final record.
        tal_nxt  = ettc_pkg::flush_tally(tal_r, cop_r, clen_r, !any_r);
        fin_tal  = tal_nxt;
        emit     = 1'b1;
        any_nxt  = 1'b1;
        cop_nxt  = hd.op;
        clen_nxt = ettc_pkg::CntOne;
        if (hd.last) took_nxt = 1'b1;
        else hd_pop = 1'b1;
      end else begin
        if (apply) begin
          op2  = hd.op;
          len2 = ettc_pkg::sat_inc(clen_r);
        end
        hd_pop   = 1'b1;
        took_nxt = 1'b0;
        if (hd.last) begin
          emit         = 1'b1;
          rec.is_final = 1'b1;
          if (len2 != '0) begin
            fin_tal        = ettc_pkg::flush_tally(tal_r, op2, len2, 1'b1);
            rec.run_op     = op2;
            rec.run_length = len2;
          end else begin
            rec.run_op     = '0;
            rec.run_length = '0;
          end
          cop_nxt  = '0;
          clen_nxt = '0;
          any_nxt  = 1'b0;
          tal_nxt  = '0;
        end else begin
          cop_nxt  = op2;
          clen_nxt = len2;
        end
      end
    end

    rec.match_count          = fin_tal.match;
    rec.mismatch_count       = fin_tal.mism;
    rec.insertion_count      = fin_tal.ins;
    rec.deletion_count       = fin_tal.del;
    rec.softclip_count       = fin_tal.sclip;
    rec.ref_aligned_length   = fin_tal.refl;
    rec.query_aligned_length = fin_tal.qry;
    rec.target_skipped       = hd.tskip;
    rec.target_kept          = hd.tkeep;

    empty   = (oc_r == '0);
    do_pop  = pop && !empty;
    out_rec = mem_r[rp_r];
    oc_nxt  = oc_r;
    if (emit && !do_pop) oc_nxt = oc_r + 1'b1;
    else if (do_pop && !emit) oc_nxt = oc_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (emit) mem_r[wp_r] <= rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cop_r  <= '0;
      clen_r <= '0;
      any_r  <= 1'b0;
      tal_r  <= '0;
      took_r <= 1'b0;
      wp_r   <= '0;
      rp_r   <= '0;
      oc_r   <= '0;
    end else begin
      cop_r  <= cop_nxt;
      clen_r <= clen_nxt;
      any_r  <= any_nxt;
      tal_r  <= tal_nxt;
      took_r <= took_nxt;
      if (emit) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      oc_r   <= oc_nxt;
    end
  end

  a_took_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    took_r |-> (hd_valid && hd.last && hd.take))
    else $error("pending final record without a last operation at the head");

  a_out_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oc_r <= (ettc_pkg::OutAw + 1)'(ettc_pkg::OutDepth))
    else $error("result queue count beyond its depth");

endmodule

FILE: sv/edit_ops_to_trimmed_cigar_core.sv
`timescale 1ns / 1ps

// Trimmed CIGAR run-length encoder.
// Input channel: push/full with in_item (op_char, last_op); a transaction
// completes on a clock edge with push high and full low. Result channel:
// the oldest run record sits on out_rec while empty is low and leaves on
// an edge with pop high. Two registers on the APB port (psel, penable,
// pwrite, paddr, pwdata, prdata, pready): the skip length at 0x0 and the
// keep length at 0x4; write them only while no alignment is in flight.
// An operation is classified in the cycle it is accepted, passes through
// a four-entry operation queue and is encoded once it reaches the head, so
// its record is written into the result queue and can leave from there.
// One operation per cycle is accepted while full is low; an operation that
// closes a run and also ends the alignment occupies the encoder once per
// record, since the encoder writes one record a cycle into the four-entry
// result queue while that queue has room.
// When the receiver stalls, the result queue fills, the encoder stops, the
// operation queue fills and full rises. Reset empties both queues, clears
// the alignment state and sets both registers to zero.

module edit_ops_to_trimmed_cigar_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  ettc_pkg::in_item_t in_item,
  output logic               empty,
  input  logic               pop,
  output ettc_pkg::out_rec_t out_rec,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [ettc_pkg::CntW-1:0] skip_r, keep_r;
  logic                      acc, enq, q_valid, q_full, hd_pop, cfg_wr;
  ettc_pkg::opq_entry_t      entry, hd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == ettc_pkg::REG_KEEP) ? 32'(keep_r) : 32'(skip_r);
  assign full   = q_full;
  assign acc    = push && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= '0;
      keep_r <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == ettc_pkg::REG_SKIP) skip_r <= pwdata[ettc_pkg::CntW-1:0];
      else keep_r <= pwdata[ettc_pkg::CntW-1:0];
    end
  end

  ettc_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .item  (in_item),
    .skip  (skip_r),
    .keep  (keep_r),
    .enq   (enq),
    .entry (entry)
  );

  ettc_opq u_opq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (enq),
    .wr_data (entry),
    .rd_en   (hd_pop),
    .rd_data (hd),
    .valid   (q_valid),
    .full    (q_full)
  );

  ettc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .hd_valid (q_valid),
    .hd       (hd),
    .hd_pop   (hd_pop),
    .empty    (empty),
    .pop      (pop),
    .out_rec  (out_rec)
  );

endmodule

FILE: dv/edit_ops_to_trimmed_cigar_core_test.sv
`timescale 1ns / 1ps

module edit_ops_to_trimmed_cigar_core_test;
  import ettc_pkg::*;

  typedef enum logic [1:0] {TRIM_SKIP, TRIM_KEEP, TRIM_ALL, TRIM_DONE} trim_stage_t;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  in_item_t    in_item;
  logic        empty;
  logic        pop;
  out_rec_t    out_rec;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  edit_ops_to_trimmed_cigar_core u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .empty   (empty),
    .pop     (pop),
    .out_rec (out_rec),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Operation stream: appended by the sequencer, indexed by the driver.
  in_item_t op_stream[$];
  out_rec_t cigar_q[$];
  int       items_offered = 0;
  int       items_taken = 0;
  int       fail_count = 0;
  int       readback_errs = 0;

  // Sender burst shaping and receiver stall control.
  int burst_left = 1;
  int gap_left = 0;
  int hold_reqs = 0;
  int hold_served = 0;
  int hold_left = 0;
  int rx_mode = 0;
  int mode_left = 0;

  // Predictor state.
  logic [CntW-1:0] skip_cfg = '0;
  logic [CntW-1:0] keep_cfg = '0;
  trim_stage_t     stage = TRIM_SKIP;
  logic [CntW-1:0] q_seen = '0;
  logic [7:0]      run_op = '0;
  logic [CntW-1:0] run_len = '0;
  logic            wrote_run = 1'b0;
  out_rec_t        tot = '0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [CntW-1:0] sat_sum(input logic [CntW-1:0] a,
                                              input logic [CntW-1:0] b);
    logic [CntW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CntW] ? {CntW{1'b1}} : s[CntW-1:0];
  endfunction

  // Closes the open run into a record, updating the running totals first.
  task automatic close_run(input logic fin);
    out_rec_t r;
    case (run_op)
      CH_I: begin
        if (fin || !wrote_run) tot.softclip_count = sat_sum(tot.softclip_count, run_len);
        else tot.insertion_count = sat_sum(tot.insertion_count, run_len);
        tot.query_aligned_length = sat_sum(tot.query_aligned_length, run_len);
      end
      CH_M, CH_EQ: begin
        tot.match_count = sat_sum(tot.match_count, run_len);
        tot.query_aligned_length = sat_sum(tot.query_aligned_length, run_len);
        tot.ref_aligned_length = sat_sum(tot.ref_aligned_length, run_len);
      end
      CH_X: begin
        tot.mismatch_count = sat_sum(tot.mismatch_count, run_len);
        tot.query_aligned_length = sat_sum(tot.query_aligned_length, run_len);
        tot.ref_aligned_length = sat_sum(tot.ref_aligned_length, run_len);
      end
      CH_D: begin
        tot.deletion_count = sat_sum(tot.deletion_count, run_len);
        tot.ref_aligned_length = sat_sum(tot.ref_aligned_length, run_len);
      end
      default: begin
      end
    endcase
    wrote_run = 1'b1;
    r = tot;
    r.is_final = fin;
    r.run_op = run_op;
    r.run_length = run_len;
    cigar_q = {cigar_q, r};
  endtask

  task automatic encode_op(input in_item_t it);
    logic [7:0] c;
    logic       qry_op;
    logic       ref_op;
    logic       take;
    out_rec_t   r;
    c = it.op_char;
    qry_op = (c == CH_M) || (c == CH_EQ) || (c == CH_X) || (c == CH_I);
    ref_op = (c == CH_M) || (c == CH_EQ) || (c == CH_X) || (c == CH_D);
    take = 1'b0;
    if (stage == TRIM_SKIP) begin
      if (q_seen < skip_cfg) begin
        if (ref_op) tot.target_skipped = sat_sum(tot.target_skipped, CntOne);
        if (qry_op) q_seen = sat_sum(q_seen, CntOne);
      end else begin
        // The operation that ends skipping is judged again by the keep rule.
        q_seen = '0;
        stage = (keep_cfg == '0) ? TRIM_ALL : TRIM_KEEP;
      end
    end
    if (stage == TRIM_KEEP) begin
      if (q_seen < keep_cfg) begin
        if (ref_op) tot.target_kept = sat_sum(tot.target_kept, CntOne);
        if (qry_op) q_seen = sat_sum(q_seen, CntOne);
        take = 1'b1;
      end else begin
        stage = TRIM_DONE;
      end
    end else if (stage == TRIM_ALL) begin
      take = 1'b1;
    end
    if (take) begin
      if (run_len != '0 && run_op != c) begin
        close_run(1'b0);
        run_len = '0;
      end
      run_op = c;
      run_len = sat_sum(run_len, CntOne);
    end
    if (it.last_op) begin
      if (run_len != '0) begin
        close_run(1'b1);
      end else begin
        r = tot;
        r.is_final = 1'b1;
        r.run_op = '0;
        r.run_length = '0;
        cigar_q = {cigar_q, r};
      end
      stage = TRIM_SKIP;
      q_seen = '0;
      run_op = '0;
      run_len = '0;
      wrote_run = 1'b0;
      tot = '0;
    end
  endtask

  task automatic check_field(input string f, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: mismatch on %s: expected %0d, got %0d", $time, f, want, got);
      fail_count++;
    end
  endtask

  // Driver: holds an open offer until it is taken, otherwise works in bursts.
  always @(negedge clk) begin
    logic     offer;
    in_item_t nxt;
    offer = push;
    nxt = in_item;
    if (items_offered != items_taken) begin
      offer = 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
      offer = 1'b0;
    end else if (rst_n && items_offered < op_stream.size()) begin
      offer = 1'b1;
      nxt = op_stream[items_offered];
      items_offered++;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      end else begin
        burst_left--;
      end
    end else begin
      offer = 1'b0;
    end
    push <= offer;
    in_item <= nxt;
  end

  // Receiver: its own stall pattern, plus long hold-offs on request.
  always @(negedge clk) begin
    logic go;
    if (hold_left > 0) begin
      hold_left--;
      go = 1'b0;
    end else if (hold_served != hold_reqs) begin
      hold_served++;
      hold_left = 300;
      go = 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        0: go = 1'b1;
        1: go = 1'($urandom_range(0, 1));
        2: go = (mode_left % 4 == 0);
        default: go = ($urandom_range(0, 6) != 0);
      endcase
    end
    pop <= go;
  end

  // Monitor: predicts on every accepted operation and checks every record.
  always @(posedge clk) begin
    out_rec_t want;
    if (rst_n) begin
      if (push && !full) begin
        encode_op(in_item);
        items_taken++;
      end
      if (pop && !empty) begin
        if (cigar_q.size() == 0) begin
          $display("%0t: unexpected record: expected none, got op %0d len %0d", $time,
                   out_rec.run_op, out_rec.run_length);
          fail_count++;
        end else begin
          want = cigar_q.pop_front();
          check_field("is_final", 32'(want.is_final), 32'(out_rec.is_final));
          check_field("run_op", 32'(want.run_op), 32'(out_rec.run_op));
          check_field("run_length", 32'(want.run_length), 32'(out_rec.run_length));
          check_field("match_count", 32'(want.match_count), 32'(out_rec.match_count));
          check_field("mismatch_count", 32'(want.mismatch_count),
                      32'(out_rec.mismatch_count));
          check_field("insertion_count", 32'(want.insertion_count),
                      32'(out_rec.insertion_count));
          check_field("deletion_count", 32'(want.deletion_count),
                      32'(out_rec.deletion_count));
          check_field("softclip_count", 32'(want.softclip_count),
                      32'(out_rec.softclip_count));
          check_field("ref_aligned_length", 32'(want.ref_aligned_length),
                      32'(out_rec.ref_aligned_length));
          check_field("query_aligned_length", 32'(want.query_aligned_length),
                      32'(out_rec.query_aligned_length));
          check_field("target_skipped", 32'(want.target_skipped),
                      32'(out_rec.target_skipped));
          check_field("target_kept", 32'(want.target_kept), 32'(out_rec.target_kept));
        end
      end
    end
  end

  task automatic cfg_write(input logic idx, input logic [CntW-1:0] val);
    logic [31:0] rd;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = {12'($urandom_range(0, 4095)), val};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_SKIP) skip_cfg = val;
    else keep_cfg = val;
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    if (rd[CntW-1:0] !== val) begin
      $display("%0t: register readback at %0d: expected %0d, got %0d", $time, paddr,
               val, rd[CntW-1:0]);
      readback_errs++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic add_op(input logic [7:0] c, input logic fin);
    in_item_t it;
    it.op_char = c;
    it.last_op = fin;
    op_stream = {op_stream, it};
  endtask

  task automatic add_ops(input string s);
    for (int i = 0; i < s.len(); i++) add_op(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick_op(input logic [7:0] prev);
    int         r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      c = prev;
    end else if (r < 90) begin
      case ($urandom_range(0, 4))
        0: c = CH_M;
        1: c = CH_EQ;
        2: c = CH_X;
        3: c = CH_I;
        default: c = CH_D;
      endcase
    end else if (r < 96) begin
      c = 8'($urandom_range(0, 255));
    end else begin
      c = 8'h00;
    end
    return c;
  endfunction

  // Mostly short alignments so that run boundaries and finals come often.
  task automatic add_alignment(output int n);
    logic [7:0] c;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
    c = CH_M;
    for (int i = 0; i < n; i++) begin
      c = pick_op(c);
      add_op(c, i == n - 1);
    end
  endtask

  task automatic wait_idle();
    while (items_taken != op_stream.size() || cigar_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [CntW-1:0] skip_v;
    logic [CntW-1:0] keep_v;
    int              added;
    int              n;
    rst_n = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin skip_v = '0; keep_v = '0; end
        1: begin skip_v = CntW'(3); keep_v = CntW'(4); end
        2: begin skip_v = {CntW{1'b1}}; keep_v = '0; end
        3: begin skip_v = '0; keep_v = {CntW{1'b1}}; end
        4: begin skip_v = CntOne; keep_v = CntOne; end
        default: begin
          skip_v = CntW'($urandom_range(0, 12));
          keep_v = ($urandom_range(0, 2) == 0) ? '0 : CntW'($urandom_range(1, 12));
        end
      endcase
      cfg_write(REG_SKIP, skip_v);
      cfg_write(REG_KEEP, keep_v);

      // Stall the receiver for a long stretch so both queues fill and full rises.
      if (ph == 1 || ph == 5) begin
        @(posedge clk);
        hold_reqs++;
      end

      if (ph == 0) begin
        add_ops("I");
        add_ops("IIMMXDD=II");
        add_ops("MMX");
        add_ops("MIIMD");
        add_op(8'h00, 1'b0);
        add_op(8'h00, 1'b0);
        add_op(8'hFF, 1'b1);
      end else if (ph == 1) begin
        // Skips four operations, keeps four query bases, then ignores the rest.
        add_ops("DMIXMMID=X");
        add_ops("DD");
      end

      added = 0;
      while (added < 125) begin
        add_alignment(n);
        added += n;
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && readback_errs == 0 && cigar_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: files.f
sv/ettc_pkg.sv
sv/ettc_front.sv
sv/ettc_opq.sv
sv/ettc_back.sv
sv/edit_ops_to_trimmed_cigar_core.sv
dv/edit_ops_to_trimmed_cigar_core_test.sv
